FILE: rtl/pcd_pkg.sv
package pcd_pkg;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_DETECT = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [2:0] KIND_VERTEX = 3'd0;
	localparam logic [2:0] KIND_EDGE   = 3'd1;
	localparam logic [2:0] KIND_STOP   = 3'd2;
	localparam logic [2:0] KIND_FOLLOW = 3'd3;
	localparam logic [2:0] KIND_NONE   = 3'd4;

	typedef enum logic [1:0] {
		PH_VERT,
		PH_EDGE,
		PH_STOP,
		PH_FOLL
	} phase_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		phase_t     phase;
		logic       load;
		logic       clear;
		logic       run_start;
		logic       pair_init;
		logic       pair_next;
		logic       len_i;
		logic       len_j;
		logic       t_init;
		logic       t_inc;
		logic       fetch;
		logic [1:0] slot;
		logic       emit_first;
		logic       emit_second;
		logic       finish;
	} pcd_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic go;
		logic pair_last;
		logic m0;
		logic m1;
		logic emit_ok;
		logic out_free;
	} pcd_sta_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] agent_a;
		logic [2:0] agent_b;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] other_x;
		logic [7:0] other_y;
		logic [5:0] time_a;
		logic [5:0] time_b;
		logic       overflow;
		logic       last;
	} res_t;

endpackage

FILE: rtl/pcd_ram.sv
module pcd_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/pcd_ctrl.sv
module pcd_ctrl
	import pcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  pcd_sta_t   sta,
	output pcd_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PHASE,
		ST_PAIR_I,
		ST_PAIR_J,
		ST_ITER,
		ST_FETCH,
		ST_WAIT,
		ST_EVAL,
		ST_EMIT0,
		ST_EMIT1,
		ST_FINAL
	} state_t;

	state_t     state_q;
	phase_t     phase_q;
	logic [1:0] slot_q;
	logic [1:0] last_slot;
	logic       acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		unique case (phase_q)
			PH_VERT: last_slot = 2'd1;
			PH_EDGE: last_slot = 2'd3;
			PH_STOP: last_slot = 2'd1;
			PH_FOLL: last_slot = 2'd2;
			default: last_slot = 2'd1;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.phase       = phase_q;
		cmd.slot        = slot_q;
		cmd.load        = acc && (command == CMD_LOAD);
		cmd.clear       = acc && (command == CMD_CLEAR);
		cmd.run_start   = acc && (command == CMD_DETECT);
		cmd.pair_init   = (state_q == ST_PHASE);
		cmd.pair_next   = (state_q == ST_ITER) && !sta.go && !sta.pair_last;
		cmd.len_i       = (state_q == ST_PAIR_I);
		cmd.len_j       = (state_q == ST_PAIR_J);
		cmd.t_init      = (state_q == ST_PAIR_J);
		cmd.fetch       = (state_q == ST_FETCH);
		cmd.emit_first  = (state_q == ST_EMIT0) && sta.emit_ok;
		cmd.emit_second = (state_q == ST_EMIT1) && sta.emit_ok;
		cmd.finish      = (state_q == ST_FINAL) && sta.out_free;
		cmd.t_inc       = ((state_q == ST_EVAL) && !sta.m0 && !sta.m1)
			|| ((state_q == ST_EMIT0) && sta.emit_ok && !sta.m1)
			|| ((state_q == ST_EMIT1) && sta.emit_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_VERT;
			slot_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc && command == CMD_DETECT) begin
						phase_q <= PH_VERT;
						state_q <= ST_PHASE;
					end
				end
				ST_PHASE:  state_q <= ST_PAIR_I;
				ST_PAIR_I: state_q <= ST_PAIR_J;
				ST_PAIR_J: state_q <= ST_ITER;
				ST_ITER: begin
					slot_q <= '0;
					if (sta.go) begin
						state_q <= ST_FETCH;
					end else if (!sta.pair_last) begin
						state_q <= ST_PAIR_I;
					end else if (phase_q == PH_FOLL) begin
						state_q <= ST_FINAL;
					end else begin
						phase_q <= phase_t'(phase_q + 2'd1);
						state_q <= ST_PHASE;
					end
				end
				ST_FETCH: begin
					slot_q <= slot_q + 2'd1;
					if (slot_q == last_slot) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (sta.m0) begin
						state_q <= ST_EMIT0;
					end else if (sta.m1) begin
						state_q <= ST_EMIT1;
					end else begin
						state_q <= ST_ITER;
					end
				end
				ST_EMIT0: begin
					if (sta.emit_ok) begin
						state_q <= sta.m1 ? ST_EMIT1 : ST_ITER;
					end
				end
				ST_EMIT1: begin
					if (sta.emit_ok) begin
						state_q <= ST_ITER;
					end
				end
				ST_FINAL: begin
					if (sta.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/pcd_dp.sv
module pcd_dp
	import pcd_pkg::*;
#(
	parameter int MAX_AGENTS    = 8,
	parameter int MAX_STEPS     = 64,
	parameter int COORD_BITS    = 8,
	parameter int MAX_CONFLICTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pcd_cmd_t   cmd,
	output pcd_sta_t   sta,
	input  logic [2:0] agent,
	input  logic [5:0] step_time,
	input  logic [7:0] cell_x,
	input  logic [7:0] cell_y,
	input  logic       step_valid,
	input  logic       path_end,
	input  logic       out_ready,
	output logic       out_valid,
	output res_t       out_res
);

	localparam int AGW = $clog2(MAX_AGENTS);
	localparam int LW  = $clog2(MAX_STEPS + 1);
	localparam int TW  = $clog2(MAX_STEPS);
	localparam int AW  = $clog2(MAX_AGENTS * MAX_STEPS);
	localparam int CNW = $clog2(MAX_CONFLICTS + 1);
	localparam int EW  = 2 * COORD_BITS + 1;

	typedef struct packed {
		logic                  v;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} ent_t;

	logic [LW-1:0]  len_q [MAX_AGENTS];
	logic [AGW-1:0] i_q, j_q, len_sel;
	logic [LW-1:0]  t_q, li_q, lj_q, mn, len_rd;
	logic [CNW-1:0] cnt_q;
	logic           over_q, pend_v_q, out_v_q;
	res_t           pend_q, out_q, res_new, out_nxt;
	logic           out_load;
	ent_t           r_q [4];
	ent_t           wr_ent, rd_ent;
	logic [1:0]     slot_s1;
	logic           cap_s1;
	logic           ld_ok, full, pairs_last, stop_last;
	logic [AGW-1:0] ag_sel;
	logic [LW-1:0]  tm_sel;
	logic [AW-1:0]  raddr, waddr;
	logic [EW-1:0]  rdata;
	logic           same01, same02, same03, same21;

	assign ld_ok = (32'(agent) < 32'(MAX_AGENTS)) && (32'(step_time) < 32'(MAX_STEPS));
	assign waddr = AW'(AW'(agent) * AW'(MAX_STEPS)) + AW'(step_time);
	assign wr_ent = '{v: step_valid, x: COORD_BITS'(cell_x), y: COORD_BITS'(cell_y)};

	always_comb begin
		ag_sel = i_q;
		tm_sel = t_q;
		unique case (cmd.phase)
			PH_VERT: begin
				ag_sel = (cmd.slot == 2'd0) ? i_q : j_q;
			end
			PH_EDGE: begin
				ag_sel = cmd.slot[1] ? j_q : i_q;
				tm_sel = cmd.slot[0] ? t_q + LW'(1) : t_q;
			end
			PH_STOP: begin
				ag_sel = (cmd.slot == 2'd0) ? i_q : j_q;
				tm_sel = (cmd.slot == 2'd0) ? li_q - LW'(1) : t_q;
			end
			PH_FOLL: begin
				ag_sel = (cmd.slot == 2'd0) ? i_q : j_q;
				tm_sel = (cmd.slot == 2'd0) ? t_q
					: (cmd.slot == 2'd1) ? t_q - LW'(1) : t_q + LW'(1);
			end
			default: ;
		endcase
	end

	assign raddr = AW'(AW'(ag_sel) * AW'(MAX_STEPS)) + AW'(TW'(tm_sel));

	pcd_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_AGENTS * MAX_STEPS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.load && ld_ok),
		.waddr(waddr),
		.wdata(wr_ent),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_ent = rdata;

	always_ff @(posedge clk) begin
		slot_s1 <= cmd.slot;
		if (cap_s1) begin
			r_q[slot_s1] <= rd_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_s1 <= 1'b0;
		end else begin
			cap_s1 <= cmd.fetch;
		end
	end

	// Path lengths and loop indices.
	assign len_sel = cmd.len_i ? i_q : j_q;
	assign len_rd  = len_q[len_sel];
	assign mn      = (li_q < lj_q) ? li_q : lj_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_AGENTS; k++) begin
				len_q[k] <= '0;
			end
		end else if (cmd.clear) begin
			for (int k = 0; k < MAX_AGENTS; k++) begin
				len_q[k] <= '0;
			end
		end else if (cmd.load && ld_ok && path_end) begin
			len_q[AGW'(agent)] <= LW'(step_time) + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pair_init) begin
			i_q <= '0;
			j_q <= (cmd.phase == PH_STOP) ? AGW'(0) : AGW'(1);
		end else if (cmd.pair_next) begin
			if (j_q == AGW'(MAX_AGENTS - 1)) begin
				i_q <= i_q + AGW'(1);
				j_q <= (cmd.phase == PH_STOP) ? AGW'(0) : i_q + AGW'(2);
			end else begin
				j_q <= j_q + AGW'(1);
			end
		end
		if (cmd.len_i) begin
			li_q <= len_rd;
		end
		if (cmd.len_j) begin
			lj_q <= len_rd;
		end
		if (cmd.t_init) begin
			t_q <= (cmd.phase == PH_STOP) ? li_q : '0;
		end else if (cmd.t_inc) begin
			t_q <= t_q + LW'(1);
		end
	end

	assign pairs_last = (i_q == AGW'(MAX_AGENTS - 2)) && (j_q == AGW'(MAX_AGENTS - 1));
	assign stop_last  = (i_q == AGW'(MAX_AGENTS - 1)) && (j_q == AGW'(MAX_AGENTS - 1));

	assign same01 = (r_q[0].x == r_q[1].x) && (r_q[0].y == r_q[1].y);
	assign same02 = (r_q[0].x == r_q[2].x) && (r_q[0].y == r_q[2].y);
	assign same03 = (r_q[0].x == r_q[3].x) && (r_q[0].y == r_q[3].y);
	assign same21 = (r_q[2].x == r_q[1].x) && (r_q[2].y == r_q[1].y);

	always_comb begin
		sta           = '0;
		full          = (cnt_q == CNW'(MAX_CONFLICTS));
		sta.out_free  = !out_v_q || out_ready;
		sta.emit_ok   = sta.out_free || !pend_v_q || full;
		res_new       = '0;
		res_new.agent_a = 3'(i_q);
		res_new.agent_b = 3'(j_q);
		res_new.pos_x   = 8'(r_q[0].x);
		res_new.pos_y   = 8'(r_q[0].y);
		res_new.time_a  = 6'(t_q);
		unique case (cmd.phase)
			PH_VERT: begin
				sta.go        = t_q < mn;
				sta.pair_last = pairs_last;
				sta.m0        = r_q[0].v && r_q[1].v && same01;
				res_new.kind  = KIND_VERTEX;
			end
			PH_EDGE: begin
				sta.go          = (t_q + LW'(1)) < mn;
				sta.pair_last   = pairs_last;
				sta.m0          = same03 && same21;
				res_new.kind    = KIND_EDGE;
				res_new.other_x = 8'(r_q[2].x);
				res_new.other_y = 8'(r_q[2].y);
				res_new.time_a  = 6'(t_q + LW'(1));
			end
			PH_STOP: begin
				sta.go         = (li_q != '0) && (i_q != j_q) && (t_q < lj_q);
				sta.pair_last  = stop_last;
				sta.m0         = r_q[1].v && same01;
				res_new.kind   = KIND_STOP;
				res_new.time_b = 6'(li_q - LW'(1));
			end
			PH_FOLL: begin
				sta.go          = t_q < mn;
				sta.pair_last   = pairs_last;
				sta.m0          = (t_q != '0) && r_q[0].v && r_q[1].v && same01;
				sta.m1          = ((t_q + LW'(1)) < lj_q) && r_q[0].v && r_q[2].v && same02;
				res_new.kind    = KIND_FOLLOW;
				res_new.agent_a = 3'(j_q);
				res_new.agent_b = 3'(i_q);
				res_new.time_a  = cmd.emit_second ? 6'(t_q + LW'(1)) : 6'(t_q - LW'(1));
				res_new.time_b  = 6'(t_q);
			end
			default: ;
		endcase
	end

	// The output register is loaded when a held result is pushed out by a
	// newer one, or at the end of a run with the final, marked result.
	assign out_load = ((cmd.emit_first || cmd.emit_second) && !full && pend_v_q)
		|| cmd.finish;

	always_comb begin
		out_nxt = pend_q;
		if (cmd.finish) begin
			if (pend_v_q) begin
				out_nxt.overflow = over_q;
				out_nxt.last     = 1'b1;
			end else begin
				out_nxt      = '0;
				out_nxt.kind = KIND_NONE;
				out_nxt.last = 1'b1;
			end
		end
	end

	// One result is held back so that the last one of a run can be marked.
	always_ff @(posedge clk) begin
		if ((cmd.emit_first || cmd.emit_second) && !full) begin
			pend_q <= res_new;
		end
		if (out_load) begin
			out_q <= out_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			over_q   <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (cmd.run_start) begin
				cnt_q    <= '0;
				over_q   <= 1'b0;
				pend_v_q <= 1'b0;
			end else if (cmd.emit_first || cmd.emit_second) begin
				if (full) begin
					over_q <= 1'b1;
				end else begin
					cnt_q    <= cnt_q + CNW'(1);
					pend_v_q <= 1'b1;
				end
			end else if (cmd.finish) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNW'(MAX_CONFLICTS))
		else $error("conflict count above cap");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		over_q |-> full)
		else $error("overflow set below cap");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.emit_first || cmd.emit_second) && pend_v_q && !full) |-> sta.out_free)
		else $error("result pushed into occupied output register");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (out_v_q && out_q.last && !pend_v_q))
		else $error("run end did not present a last result");

endmodule

FILE: rtl/path_conflict_detector.sv
// Multi-agent path conflict detector.
// Input channel (in_valid/in_ready): each beat carries a command. A load beat
// writes one timed step of one agent's path into the step memory and, when
// path_end is set, sets that agent's path length. A clear beat zeroes all path
// lengths. A detect beat starts a run that checks every agent pair for vertex,
// edge, stopping and follow conflicts, in that order.
// Output channel (out_valid/out_ready): one beat per conflict, at most
// MAX_CONFLICTS per run; the final beat of a run has last set and carries the
// overflow flag. A run with no conflict gives one beat of kind "none".
// Loads and clears are taken one per cycle, back to back, outside a run. A
// run is sequenced over the single read port of the step memory: each
// checked time step fetches two to four entries and emits each conflict
// found there; each pair first reads both path lengths and each of the four
// phases resets its pairs. The input channel is held off for the whole run.
// The output register takes results as soon as the receiver frees it; a
// stalled receiver stalls the run at its next result.
// Reset clears the path lengths and the sequencer; the step memory is not
// cleared, so there is no clearing pass and the block is ready right away.
module path_conflict_detector
	import pcd_pkg::*;
#(
	parameter int MAX_AGENTS    = 8,
	parameter int MAX_STEPS     = 64,
	parameter int COORD_BITS    = 8,
	parameter int MAX_CONFLICTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [2:0] agent,
	input  logic [5:0] step_time,
	input  logic [7:0] cell_x,
	input  logic [7:0] cell_y,
	input  logic       step_valid,
	input  logic       path_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [2:0] agent_a,
	output logic [2:0] agent_b,
	output logic [7:0] pos_x,
	output logic [7:0] pos_y,
	output logic [7:0] other_x,
	output logic [7:0] other_y,
	output logic [5:0] time_a,
	output logic [5:0] time_b,
	output logic       overflow,
	output logic       last
);

	pcd_cmd_t cmd;
	pcd_sta_t sta;
	res_t     res;

	// Sequencer: walks phases, agent pairs, time steps and memory fetches.
	pcd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command (command),
		.sta     (sta),
		.cmd     (cmd)
	);

	// Datapath: step memory, path lengths, compares and the result registers.
	pcd_dp #(
		.MAX_AGENTS   (MAX_AGENTS),
		.MAX_STEPS    (MAX_STEPS),
		.COORD_BITS   (COORD_BITS),
		.MAX_CONFLICTS(MAX_CONFLICTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sta       (sta),
		.agent     (agent),
		.step_time (step_time),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.step_valid(step_valid),
		.path_end  (path_end),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_res   (res)
	);

	// The result register drives the output fields directly.
	assign kind     = res.kind;
	assign agent_a  = res.agent_a;
	assign agent_b  = res.agent_b;
	assign pos_x    = res.pos_x;
	assign pos_y    = res.pos_y;
	assign other_x  = res.other_x;
	assign other_y  = res.other_y;
	assign time_a   = res.time_a;
	assign time_b   = res.time_b;
	assign overflow = res.overflow;
	assign last     = res.last;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the path conflict detector.
// An initial block builds a list of beats: a directed part that hits each
// conflict kind, one-step and empty paths, invalid steps, the result cap,
// clears and the unused command, then random paths and noise. A clocked
// driver sends those beats in bursts. At each accepted beat it updates a
// shadow copy of the step memory and path lengths, and for a detect beat it
// computes the whole list of conflicts that the run must produce. A clocked
// monitor stalls the output on its own pattern and checks every result beat
// against the oldest expected conflict.
module tb_top;
	import pcd_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] command = CMD_LOAD;
	logic [2:0] agent = '0;
	logic [5:0] step_time = '0;
	logic [7:0] cell_x = '0;
	logic [7:0] cell_y = '0;
	logic       step_valid = 1'b0;
	logic       path_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] kind;
	logic [2:0] agent_a;
	logic [2:0] agent_b;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [7:0] other_x;
	logic [7:0] other_y;
	logic [5:0] time_a;
	logic [5:0] time_b;
	logic       overflow;
	logic       last;

	path_conflict_detector dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .agent(agent), .step_time(step_time),
		.cell_x(cell_x), .cell_y(cell_y), .step_valid(step_valid),
		.path_end(path_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .agent_a(agent_a), .agent_b(agent_b),
		.pos_x(pos_x), .pos_y(pos_y), .other_x(other_x), .other_y(other_y),
		.time_a(time_a), .time_b(time_b), .overflow(overflow), .last(last)
	);

	always #5 clk = ~clk;

	// One input beat as the generator queues it.
	typedef struct {
		logic [1:0] cmd;
		logic [2:0] ag;
		logic [5:0] tm;
		logic [7:0] x;
		logic [7:0] y;
		logic       v;
		logic       e;
	} beat_t;

	beat_t pending_beats[$];
	res_t  expected_conflicts[$];
	int    errors = 0;
	int    cycles = 0;
	bit    stimulus_done = 1'b0;

	// Which steps the generator has written, so that no path ever ends past
	// a step that was never loaded.
	bit    gen_written[8][64];

	// Shadow state of the block, updated as beats are accepted.
	logic [7:0] shadow_x[8][64];
	logic [7:0] shadow_y[8][64];
	bit         shadow_v[8][64];
	int         shadow_len[8];
	int         run_count;
	bit         run_over;

	// ---------------------------------------------------------------
	// Conflict prediction
	// ---------------------------------------------------------------

	// Appends one conflict to the expected list unless the cap is reached.
	task automatic add_conflict(logic [2:0] k, int a, int b, logic [7:0] px, logic [7:0] py,
			logic [7:0] ox, logic [7:0] oy, int ta, int tb);
		res_t r;
		if (run_count >= 64) begin
			run_over = 1'b1;
		end else begin
			r.kind = k;
			r.agent_a = a[2:0];
			r.agent_b = b[2:0];
			r.pos_x = px;
			r.pos_y = py;
			r.other_x = ox;
			r.other_y = oy;
			r.time_a = ta[5:0];
			r.time_b = tb[5:0];
			r.overflow = 1'b0;
			r.last = 1'b0;
			expected_conflicts.insert(expected_conflicts.size(), r);
			run_count++;
		end
	endtask

	function automatic bit same_cell(int a, int ta, int b, int tb);
		return shadow_x[a][ta] == shadow_x[b][tb] && shadow_y[a][ta] == shadow_y[b][tb];
	endfunction

	// Walks all agent pairs in the block's order: vertex, edge, stopping,
	// then follow conflicts.
	task automatic predict_conflicts();
		int mn;
		int li;
		int lj;
		res_t r;
		run_count = 0;
		run_over = 1'b0;
		for (int i = 0; i < 8; i++)
			for (int j = i + 1; j < 8; j++) begin
				mn = shadow_len[i] < shadow_len[j] ? shadow_len[i] : shadow_len[j];
				for (int t = 0; t < mn; t++)
					if (shadow_v[i][t] && shadow_v[j][t] && same_cell(i, t, j, t))
						add_conflict(KIND_VERTEX, i, j, shadow_x[i][t], shadow_y[i][t],
							0, 0, t, 0);
			end
		// Swaps; a pair with a path shorter than two steps has none.
		for (int i = 0; i < 8; i++)
			for (int j = i + 1; j < 8; j++) begin
				mn = shadow_len[i] < shadow_len[j] ? shadow_len[i] : shadow_len[j];
				for (int t = 0; t + 1 < mn; t++)
					if (same_cell(i, t, j, t + 1) && same_cell(j, t, i, t + 1))
						add_conflict(KIND_EDGE, i, j, shadow_x[i][t], shadow_y[i][t],
							shadow_x[j][t], shadow_y[j][t], t + 1, 0);
			end
		// Another agent still moving onto a finished agent's goal.
		for (int i = 0; i < 8; i++) begin
			li = shadow_len[i];
			if (li == 0)
				continue;
			for (int j = 0; j < 8; j++) begin
				if (i == j)
					continue;
				for (int t = li; t < shadow_len[j]; t++)
					if (shadow_v[j][t] && same_cell(j, t, i, li - 1))
						add_conflict(KIND_STOP, i, j, shadow_x[i][li - 1],
							shadow_y[i][li - 1], 0, 0, t, li - 1);
			end
		end
		// One agent entering a cell the other held one step apart.
		for (int i = 0; i < 8; i++) begin
			li = shadow_len[i];
			if (li == 0)
				continue;
			for (int j = i + 1; j < 8; j++) begin
				lj = shadow_len[j];
				if (lj == 0)
					continue;
				mn = li < lj ? li : lj;
				for (int t = 0; t < mn; t++) begin
					if (t > 0 && shadow_v[i][t] && shadow_v[j][t - 1] &&
							same_cell(i, t, j, t - 1))
						add_conflict(KIND_FOLLOW, j, i, shadow_x[i][t], shadow_y[i][t],
							0, 0, t - 1, t);
					if (t + 1 < lj && shadow_v[i][t] && shadow_v[j][t + 1] &&
							same_cell(i, t, j, t + 1))
						add_conflict(KIND_FOLLOW, j, i, shadow_x[i][t], shadow_y[i][t],
							0, 0, t + 1, t);
				end
			end
		end
		if (run_count == 0)
			add_conflict(KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0);
		r = expected_conflicts.pop_back();
		r.overflow = run_over;
		r.last = 1'b1;
		expected_conflicts.insert(expected_conflicts.size(), r);
	endtask

	task automatic apply_beat(beat_t b);
		case (b.cmd)
			CMD_LOAD: begin
				shadow_x[b.ag][b.tm] = b.x;
				shadow_y[b.ag][b.tm] = b.y;
				shadow_v[b.ag][b.tm] = b.v;
				if (b.e)
					shadow_len[b.ag] = b.tm + 1;
			end
			CMD_DETECT: predict_conflicts();
			CMD_CLEAR: begin
				for (int a = 0; a < 8; a++)
					shadow_len[a] = 0;
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------
	// Stimulus generation
	// ---------------------------------------------------------------

	task automatic queue_beat(logic [1:0] c, int ag, int tm, int x, int y, bit v, bit e);
		beat_t b;
		b.cmd = c;
		b.ag = ag[2:0];
		b.tm = tm[5:0];
		b.x = x[7:0];
		b.y = y[7:0];
		b.v = v;
		b.e = e;
		if (c == CMD_LOAD)
			gen_written[ag][tm] = 1'b1;
		pending_beats.insert(pending_beats.size(), b);
	endtask

	// Loads a whole path; a small span packs the agents close together so
	// that conflicts are common.
	task automatic queue_path(int ag, int len, int span);
		for (int t = 0; t < len; t++)
			queue_beat(CMD_LOAD, ag, t, $urandom_range(span, 0), $urandom_range(span, 0),
				$urandom_range(9, 0) != 0, t == len - 1);
	endtask

	// Noise load: a path end is only marked when every earlier step exists.
	task automatic queue_noise_load();
		int ag;
		int tm;
		bit ok;
		ag = $urandom_range(7, 0);
		tm = $urandom_range(63, 0);
		ok = 1'b1;
		for (int t = 0; t < tm; t++)
			if (!gen_written[ag][t])
				ok = 1'b0;
		queue_beat(CMD_LOAD, ag, tm, $urandom_range(255, 0), $urandom_range(255, 0),
			$urandom_range(1, 0), ok && $urandom_range(1, 0));
	endtask

	initial begin
		int sel;
		int len;
		// Directed part. Detect on empty paths: a single "none" result.
		queue_beat(CMD_DETECT, 0, 0, 0, 0, 0, 0);
		// Vertex, edge swap and follow between agents 0 and 1, partly at the far corner.
		queue_beat(CMD_LOAD, 0, 0, 255, 255, 1, 0);
		queue_beat(CMD_LOAD, 0, 1, 0, 0, 1, 0);
		queue_beat(CMD_LOAD, 0, 2, 7, 7, 1, 1);
		queue_beat(CMD_LOAD, 1, 0, 0, 0, 1, 0);
		queue_beat(CMD_LOAD, 1, 1, 255, 255, 1, 0);
		queue_beat(CMD_LOAD, 1, 2, 7, 7, 1, 0);
		// Agent 1 runs on across agent 0's goal: a stopping conflict.
		queue_beat(CMD_LOAD, 1, 3, 7, 7, 1, 1);
		// One-step path for agent 7 on an invalid step.
		queue_beat(CMD_LOAD, 7, 0, 7, 7, 0, 1);
		queue_beat(CMD_DETECT, 0, 0, 0, 0, 0, 0);
		// The unused command changes nothing; clear empties every path.
		queue_beat(2'd3, 0, 0, 0, 0, 0, 0);
		queue_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		queue_beat(CMD_DETECT, 0, 0, 0, 0, 0, 0);
		pending_beats.delete(0);
		pending_beats.push_front(pending_beats[0]);
		pending_beats[0].cmd = CMD_DETECT;
		// Two agents parked on one cell for 40 steps overrun the result cap.
		for (int t = 0; t < 40; t++) begin
			queue_beat(CMD_LOAD, 2, t, 255, 0, 1, t == 39);
			queue_beat(CMD_LOAD, 3, t, 255, 0, 1, t == 39);
		end
		queue_beat(CMD_DETECT, 0, 0, 0, 0, 0, 0);
		// Full-length path, last time step at its maximum.
		queue_path(4, 64, 255);
		queue_beat(CMD_DETECT, 0, 0, 0, 0, 0, 0);
		queue_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0);

		// Random part: mostly short well-formed paths, then detection.
		while (pending_beats.size() < 300) begin
			sel = $urandom_range(99, 0);
			if (sel < 55) begin
				len = ($urandom_range(49, 0) == 0) ? 64 : $urandom_range(8, 1);
				queue_path($urandom_range(7, 0), len,
					($urandom_range(3, 0) == 0) ? 255 : 3);
			end else if (sel < 75) begin
				queue_beat(CMD_DETECT, 0, 0, 0, 0, 0, 0);
			end else if (sel < 80) begin
				queue_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
			end else if (sel < 83) begin
				queue_beat(2'd3, $urandom_range(7, 0), $urandom_range(63, 0),
					$urandom_range(255, 0), $urandom_range(255, 0), 1, 1);
			end else begin
				queue_noise_load();
			end
		end
		queue_beat(CMD_DETECT, 0, 0, 0, 0, 0, 0);
		stimulus_done = 1'b1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_beats.size() == 0 && !in_valid && expected_conflicts.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_conflicts.size() == 0) begin
			$display("PASS path_conflict_detector");
		end else begin
			$display("FAIL path_conflict_detector");
		end
		$finish;
	end

	// ---------------------------------------------------------------
	// Driver: bursts of beats with random gaps between them.
	// ---------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		beat_t cur;
		beat_t nxt;
		bit    hold;
		if (arst_n) begin
			hold = in_valid;
			if (in_valid && in_ready) begin
				cur.cmd = command;
				cur.ag = agent;
				cur.tm = step_time;
				cur.x = cell_x;
				cur.y = cell_y;
				cur.v = step_valid;
				cur.e = path_end;
				apply_beat(cur);
				hold = 1'b0;
			end
			if (!hold) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (stimulus_done && pending_beats.size() > 0) begin
					nxt = pending_beats.pop_front();
					command <= nxt.cmd;
					agent <= nxt.ag;
					step_time <= nxt.tm;
					cell_x <= nxt.x;
					cell_y <= nxt.y;
					step_valid <= nxt.v;
					path_end <= nxt.e;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(20, 0);
						gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: stalls the output and checks each result beat.
	// ---------------------------------------------------------------
	int stall_left = 0;
	int quiet_left = 0;

	task automatic check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_conflicts.size() == 0) begin
					$error("result beat with no conflict expected");
					errors++;
				end else begin
					e = expected_conflicts.pop_front();
					check_field("kind", e.kind, kind);
					check_field("agent_a", e.agent_a, agent_a);
					check_field("agent_b", e.agent_b, agent_b);
					check_field("pos_x", e.pos_x, pos_x);
					check_field("pos_y", e.pos_y, pos_y);
					check_field("other_x", e.other_x, other_x);
					check_field("other_y", e.other_y, other_y);
					check_field("time_a", e.time_a, time_a);
					check_field("time_b", e.time_b, time_b);
					check_field("overflow", e.overflow, overflow);
					check_field("last", e.last, last);
				end
			end
			// Alternate stretches of full readiness with stretches of stalls.
			if (quiet_left > 0) begin
				quiet_left--;
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				case ($urandom_range(19, 0))
					0: quiet_left = $urandom_range(150, 20);
					1: stall_left = $urandom_range(25, 5);
					2, 3, 4, 5: stall_left = $urandom_range(2, 0);
					default: ;
				endcase
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 100000000) begin
			$display("FAIL path_conflict_detector");
			$finish;
		end
	end

endmodule
